>>> design/mhtp_pkg.sv
// ----------------------------------------------------------------------------
// mhtp_pkg - shared types and constants of the music header tag parser
// Event codes, parser phases, the result word and the tag byte constants.
// ----------------------------------------------------------------------------
package mhtp_pkg;

	// Field widths
	localparam int DATA_W  = 8;
	localparam int EVENT_W = 4;
	localparam int INDEX_W = 7;
	localparam int VALUE_W = 16;

	// Event codes reported on the result channel
	typedef enum logic [EVENT_W-1:0] {
		EV_TITLE   = 4'd0,
		EV_AUTHOR  = 4'd1,
		EV_COMMENT = 4'd2,
		EV_SONGS   = 4'd3,
		EV_DEFAULT = 4'd4,
		EV_VBL     = 4'd5,
		EV_TIMER   = 4'd6,
		EV_LENGTH  = 4'd7,
		EV_NAMEOFS = 4'd8,
		EV_END     = 4'd9,
		EV_BADTAG  = 4'd10,
		EV_NOEND   = 4'd11
	} event_t;

	// Parser phase
	typedef enum logic [3:0] {
		PH_TAG     = 4'd0,
		PH_SKIP    = 4'd1,
		PH_PAD     = 4'd2,
		PH_SONGS   = 4'd3,
		PH_DEFAULT = 4'd4,
		PH_VBL     = 4'd5,
		PH_TA      = 4'd6,
		PH_TB      = 4'd7,
		PH_TC      = 4'd8,
		PH_TD      = 4'd9,
		PH_TIME    = 4'd10,
		PH_SN      = 4'd11
	} phase_t;

	// Four-letter tags, in priority order
	typedef enum logic [2:0] {
		LT_HDNS = 3'd0,
		LT_TITL = 3'd1,
		LT_COMM = 3'd2,
		LT_RIPP = 3'd3,
		LT_CONV = 3'd4,
		LT_YEAR = 3'd5,
		LT_TIME = 3'd6,
		LT_SN   = 3'd7
	} tag_id_t;

	localparam int NUM_LONG_TAGS = 8;

	localparam logic [31:0] LONG_TAGS [NUM_LONG_TAGS] = '{
		32'h48444E53,  // HDNS
		32'h5449544C,  // TITL
		32'h434F4D4D,  // COMM
		32'h52495050,  // RIPP
		32'h434F4E56,  // CONV
		32'h59454152,  // YEAR
		32'h54494D45,  // TIME
		32'h2123534E   // !#SN
	};

	// Single characters used by the short tags
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_V    = 8'h56;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;

	// Number clamps
	localparam logic [9:0] NUM_MAX2 = 10'd99;
	localparam logic [9:0] NUM_MAX3 = 10'd999;

	// One result item
	typedef struct packed {
		event_t               ev;
		logic [INDEX_W-1:0]   index;
		logic [VALUE_W-1:0]   value;
		logic                 final_res;
	} result_t;

endpackage

>>> design/mhtp_if.sv
// ----------------------------------------------------------------------------
// mhtp_if - request channels of the music header tag parser
// Byte channel into the parser and event channel out of it.
// ----------------------------------------------------------------------------
interface mhtp_byte_if;
	import mhtp_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface mhtp_event_if;
	import mhtp_pkg::*;

	logic               valid;
	logic               ready;
	logic [EVENT_W-1:0] event_res;
	logic [INDEX_W-1:0] index;
	logic [VALUE_W-1:0] value;
	logic               final_res;

	modport source (output valid, event_res, index, value, final_res, input ready);
	modport sink (input valid, event_res, index, value, final_res, output ready);
endinterface

>>> design/music_header_tag_parser.sv
// ----------------------------------------------------------------------------
// music_header_tag_parser - header tag area parser
// Takes the tag area one byte per request and reports each tag as an event.
// ----------------------------------------------------------------------------
// Output: the events of a byte are written into the result queue when the byte
//   is accepted and leave it in order on the event channel.
// Throughput: one byte per cycle while the four-entry result queue has two free
//   slots; a byte that gives two events puts both into the queue.
// Reset: arst_n clears the parse state and empties the result queue.
module music_header_tag_parser (
	input  logic                clk,
	input  logic                arst_n,
	mhtp_byte_if.sink           byte_ch,
	mhtp_event_if.source        event_ch
);
	import mhtp_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Result of feeding one char to a number field
	typedef struct packed {
		logic               term;
		event_t             ev;
		logic [INDEX_W-1:0] idx;
		logic [9:0]         val;
		logic [9:0]         acc;
		logic [1:0]         cnt;
	} num_res_t;

	function automatic num_res_t num_step(input phase_t ph, input logic [9:0] acc,
		input logic [1:0] cnt, input logic [7:0] b);
		logic       three;
		logic [9:0] maxv;
		logic [13:0] prod;
		logic [3:0] tnum;
		num_res_t   r;
		three  = (ph >= PH_TA);
		maxv   = three ? NUM_MAX3 : NUM_MAX2;
		prod   = {4'd0, acc} * 14'd10 + {10'd0, b[3:0]};
		tnum   = ph - PH_TA;
		r.term = 1'b0;
		r.ev   = EV_DEFAULT;
		r.idx  = '0;
		r.val  = '0;
		r.acc  = acc;
		r.cnt  = cnt;
		if (b == 8'd0) begin
			r.term = 1'b1;
			r.val  = (acc > maxv) ? maxv : acc;
			case (ph)
				PH_SONGS:   r.ev = EV_SONGS;
				PH_DEFAULT: r.ev = EV_DEFAULT;
				PH_VBL:     r.ev = EV_VBL;
				default: begin
					r.ev  = EV_TIMER;
					r.idx = {5'd0, tnum[1:0]};
				end
			endcase
		end else if (cnt < (three ? 2'd3 : 2'd2)) begin
			r.cnt = cnt + 2'd1;
			if (b >= CH_0 && b <= CH_9) r.acc = prod[9:0];
		end
		return r;
	endfunction

	// Parse state
	phase_t             ph_q, ph_d;
	logic [31:0]        win_q, win_d;
	logic [2:0]         fill_q, fill_d;
	logic [9:0]         acc_q, acc_d;
	logic [1:0]         cnt_q, cnt_d;
	logic [INDEX_W-1:0] songs_q, songs_d;
	logic [INDEX_W-1:0] widx_q, widx_d;
	logic [7:0]         whigh_q, whigh_d;
	logic [VALUE_W-1:0] ofs_q, ofs_d;
	logic [VALUE_W-1:0] start_q, start_d;
	logic               fin_q, fin_d;

	// Result queue
	result_t            fifo_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QPTR_W:0]    count_q;

	logic               accept, pop;
	logic [7:0]         b;
	logic [31:0]        win_sh;
	logic [2:0]         fill_inc;
	logic [VALUE_W-1:0] start_t;
	logic               pre_ok, hit_any;
	tag_id_t            hit_id;
	num_res_t           num_main, num_dflt;
	logic               ev_v, noend_v;
	result_t            ev_r, r0, r1;
	logic [1:0]         n_push;

	assign b      = byte_ch.data_byte;
	assign accept = byte_ch.valid && byte_ch.ready;
	assign pop    = event_ch.valid && event_ch.ready;

	// Tag window lookahead and matching
	assign win_sh   = {win_q[23:0], b};
	assign fill_inc = fill_q + 3'd1;
	assign start_t  = (fill_q == 3'd0) ? ofs_q : start_q;

	always_comb begin
		pre_ok  = 1'b0;
		hit_any = 1'b0;
		hit_id  = LT_HDNS;
		for (int i = NUM_LONG_TAGS - 1; i >= 0; i--) begin
			if ((fill_inc == 3'd1 && LONG_TAGS[i][31:24] == win_sh[7:0]) ||
			    (fill_inc == 3'd2 && LONG_TAGS[i][31:16] == win_sh[15:0]) ||
			    (fill_inc == 3'd3 && LONG_TAGS[i][31:8] == win_sh[23:0]))
				pre_ok = 1'b1;
			if (LONG_TAGS[i] == win_sh) begin
				hit_any = 1'b1;
				hit_id  = tag_id_t'(i[2:0]);
			end
		end
	end

	assign num_main = num_step(ph_q, acc_q, cnt_q, b);
	assign num_dflt = num_step(PH_DEFAULT, 10'd0, {1'b0, fill_inc == 3'd4}, b);

	// Next parse state and the event of this byte
	always_comb begin
		logic tag_go;
		logic [15:0] w;
		tag_go  = 1'b0;
		w       = {whigh_q, b};
		ph_d    = ph_q;
		win_d   = win_q;
		fill_d  = fill_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		songs_d = songs_q;
		widx_d  = widx_q;
		whigh_d = whigh_q;
		ofs_d   = ofs_q;
		start_d = start_q;
		fin_d   = fin_q;
		ev_v    = 1'b0;
		ev_r    = '0;
		noend_v = 1'b0;

		if (!fin_q) begin
			ofs_d = ofs_q + 16'd1;
			unique case (ph_q)
				PH_TAG: tag_go = 1'b1;
				PH_PAD: tag_go = (b != 8'd0);
				PH_SKIP: if (b == 8'd0) ph_d = PH_TAG;
				PH_SONGS, PH_DEFAULT, PH_VBL, PH_TA, PH_TB, PH_TC, PH_TD: begin
					acc_d = num_main.acc;
					cnt_d = num_main.cnt;
					if (num_main.term) begin
						ev_v       = 1'b1;
						ev_r.ev    = num_main.ev;
						ev_r.index = num_main.idx;
						ev_r.value = {6'd0, num_main.val};
						ph_d       = PH_PAD;
						if (ph_q == PH_SONGS) songs_d = num_main.val[INDEX_W-1:0];
					end
				end
				PH_TIME, PH_SN: begin
					if (fill_q == 3'd0) begin
						whigh_d = b;
						fill_d  = 3'd1;
					end else begin
						fill_d     = 3'd0;
						ev_v       = 1'b1;
						ev_r.index = widx_q;
						if (ph_q == PH_SN) begin
							ev_r.ev    = EV_NAMEOFS;
							ev_r.value = w + start_q;
						end else begin
							ev_r.ev    = EV_LENGTH;
							ev_r.value = w;
						end
						widx_d = widx_q + 7'd1;
						if (widx_d >= songs_q) ph_d = PH_TAG;
					end
				end
				default: ph_d = PH_TAG;
			endcase

			// Tag recognition
			if (tag_go) begin
				ph_d    = PH_TAG;
				start_d = start_t;
				win_d   = win_sh;
				fill_d  = fill_inc;
				if (fill_inc == 3'd2 && win_sh[15:0] == {CH_HASH, CH_HASH}) begin
					ph_d = PH_SONGS;
					win_d = '0; fill_d = '0; acc_d = '0; cnt_d = '0;
				end else if (fill_inc == 3'd2 && win_sh[15:0] == {CH_BANG, CH_V}) begin
					ph_d = PH_VBL;
					win_d = '0; fill_d = '0; acc_d = '0; cnt_d = '0;
				end else if (fill_inc == 3'd2 && win_sh[15:8] == CH_T &&
				             b >= CH_A && b <= CH_D) begin
					ph_d = phase_t'(PH_TA + {2'd0, b[1:0] - 2'd1});
					win_d = '0; fill_d = '0; acc_d = '0; cnt_d = '0;
				end else if ((fill_inc == 3'd3 && win_sh[23:8] == {CH_BANG, CH_HASH} &&
				              b != CH_S) ||
				             (fill_inc == 3'd4 && win_sh[31:8] == {CH_BANG, CH_HASH, CH_S} &&
				              b != CH_N)) begin
					// default-song number that starts inside the lookahead
					win_d  = '0;
					fill_d = '0;
					acc_d  = num_dflt.acc;
					cnt_d  = num_dflt.cnt;
					ph_d   = num_dflt.term ? PH_PAD : PH_DEFAULT;
					if (num_dflt.term) begin
						ev_v       = 1'b1;
						ev_r.ev    = EV_DEFAULT;
						ev_r.value = {6'd0, num_dflt.val};
					end
				end else if (fill_inc == 3'd4) begin
					win_d  = '0;
					fill_d = '0;
					if (!hit_any) begin
						ev_v       = 1'b1;
						ev_r.ev    = EV_BADTAG;
						ev_r.value = start_t;
						fin_d      = 1'b1;
					end else begin
						unique case (hit_id)
							LT_HDNS: begin
								ev_v       = 1'b1;
								ev_r.ev    = EV_END;
								ev_r.value = ofs_q + 16'd2;
								fin_d      = 1'b1;
							end
							LT_TITL: begin
								ev_v = 1'b1; ev_r.ev = EV_TITLE;
								ev_r.value = ofs_d; ph_d = PH_SKIP;
							end
							LT_COMM: begin
								ev_v = 1'b1; ev_r.ev = EV_AUTHOR;
								ev_r.value = ofs_d; ph_d = PH_SKIP;
							end
							LT_RIPP: begin
								ev_v = 1'b1; ev_r.ev = EV_COMMENT;
								ev_r.value = ofs_d; ph_d = PH_SKIP;
							end
							LT_CONV, LT_YEAR: ph_d = PH_SKIP;
							LT_TIME, LT_SN: begin
								ph_d = (songs_q == '0) ? PH_TAG :
								       ((hit_id == LT_SN) ? PH_SN : PH_TIME);
								widx_d  = '0;
								whigh_d = '0;
							end
							default: ph_d = PH_TAG;
						endcase
					end
				end else if (!pre_ok && !(fill_inc == 3'd1 && b == CH_HASH)) begin
					ev_v       = 1'b1;
					ev_r.ev    = EV_BADTAG;
					ev_r.value = start_t;
					win_d      = '0;
					fill_d     = '0;
					fin_d      = 1'b1;
				end
			end

			// Out of input before the end marker
			if (!fin_d && byte_ch.last_byte) begin
				noend_v = 1'b1;
				fin_d   = 1'b1;
			end
		end
	end

	// Order the results of this byte and mark the last one
	always_comb begin
		result_t ne;
		ne           = '0;
		ne.ev        = EV_NOEND;
		ne.value     = ofs_d;
		ne.final_res = 1'b1;
		r0           = ev_r;
		r0.final_res = !noend_v;
		r1           = ne;
		if (!ev_v) r0 = ne;
		n_push = {1'b0, ev_v} + {1'b0, noend_v};
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_TAG;
			win_q   <= '0;
			fill_q  <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			songs_q <= 7'd1;
			widx_q  <= '0;
			whigh_q <= '0;
			ofs_q   <= '0;
			start_q <= '0;
			fin_q   <= 1'b0;
		end else if (accept) begin
			ph_q    <= ph_d;
			win_q   <= win_d;
			fill_q  <= fill_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			songs_q <= songs_d;
			widx_q  <= widx_d;
			whigh_q <= whigh_d;
			ofs_q   <= ofs_d;
			start_q <= start_d;
			fin_q   <= fin_d;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (accept) wr_q <= wr_q + n_push;
			if (pop) rd_q <= rd_q + {{(QPTR_W-1){1'b0}}, 1'b1};
			count_q <= count_q + (accept ? {1'b0, n_push} : 3'd0) - {2'd0, pop};
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (accept && n_push != 2'd0) fifo_q[wr_q] <= r0;
		if (accept && n_push == 2'd2) fifo_q[wr_q + {{(QPTR_W-1){1'b0}}, 1'b1}] <= r1;
	end

	// Ready while two result slots are free
	assign byte_ch.ready      = (count_q <= 3'(QDEPTH - 2));
	assign event_ch.valid     = (count_q != '0);
	assign event_ch.event_res = fifo_q[rd_q].ev;
	assign event_ch.index     = fifo_q[rd_q].index;
	assign event_ch.value     = fifo_q[rd_q].value;
	assign event_ch.final_res = fifo_q[rd_q].final_res;

endmodule

>>> design/mhtp_checker.sv
// ----------------------------------------------------------------------------
// mhtp_checker - port checks for the music header tag parser
// Watches the event channel and is bound to the top level.
// ----------------------------------------------------------------------------
module mhtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  event_res,
	input logic [6:0]  index,
	input logic        final_res
);
	import mhtp_pkg::*;

	// A waiting event is held until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res))
		else $error("event dropped or changed while stalled");

	// Running out of input is always the last result of its byte
	a_noend_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_NOEND |-> final_res)
		else $error("noend not marked final");

	// Only timer, length and name offset events carry an index
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_TIMER && event_res != EV_LENGTH &&
		event_res != EV_NAMEOFS |-> index == '0)
		else $error("index set on an event without one");

	// Nothing follows the final result of a finished parse
	a_quiet_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_res &&
		(event_res == EV_END || event_res == EV_BADTAG || event_res == EV_NOEND)
		|=> !out_valid)
		else $error("event after the parse finished");

endmodule

bind music_header_tag_parser mhtp_checker u_mhtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (event_ch.valid),
	.out_ready (event_ch.ready),
	.event_res (event_ch.event_res),
	.index     (event_ch.index),
	.final_res (event_ch.final_res)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the music header tag parser
// Feeds one long tag area (a directed opening, then random well-formed tags,
// then one closing case), predicts every event in step with the accepted
// bytes and compares each received event field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	import mhtp_pkg::*;

	// One byte request as planned; typed rows carry their own event
	typedef struct {
		logic [DATA_W-1:0] data;
		logic              last;
		bit                typed;
		result_t           want;
	} byte_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]  data;
		logic               typed;
		event_t             ev;
		logic [INDEX_W-1:0] idx;
		logic [VALUE_W-1:0] val;
	} opening_row_t;

	// Directed opening: title, song count, timer at its clamp, name offsets
	opening_row_t opening [25] = '{
		'{CH_T,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{8'h49,       1'b0, EV_TITLE,  7'd0, 16'd0},   // I
		'{CH_T,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{8'h4C,       1'b1, EV_TITLE,  7'd0, 16'd4},   // L: string at offset 4
		'{8'h00,       1'b0, EV_TITLE,  7'd0, 16'd0},   // empty string
		'{CH_HASH,     1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_HASH,     1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_0 + 8'd2, 1'b0, EV_TITLE,  7'd0, 16'd0},
		'{8'h78,       1'b0, EV_TITLE,  7'd0, 16'd0},   // x: not a digit
		'{8'h00,       1'b1, EV_SONGS,  7'd0, 16'd2},
		'{CH_T,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_D,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_9,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_9,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_9,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_9,        1'b0, EV_TITLE,  7'd0, 16'd0},   // beyond three chars
		'{8'h00,       1'b1, EV_TIMER,  7'd3, 16'd999},
		'{CH_BANG,     1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_HASH,     1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_S,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{CH_N,        1'b0, EV_TITLE,  7'd0, 16'd0},
		'{8'hFF,       1'b0, EV_TITLE,  7'd0, 16'd0},   // words wrap with offset
		'{8'hFF,       1'b0, EV_TITLE,  7'd0, 16'd0},
		'{8'h00,       1'b0, EV_TITLE,  7'd0, 16'd0},
		'{8'h00,       1'b0, EV_TITLE,  7'd0, 16'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mhtp_byte_if  byte_ch ();
	mhtp_event_if event_ch ();

	music_header_tag_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.event_ch (event_ch)
	);

	always #5 clk = ~clk;

	byte_req_t byte_plan [$];
	result_t   pending_events [$];
	int        gen_songs;
	int        bytes_taken = 0;
	int        bytes_ignored = 0;
	int        events_checked = 0;
	int        mismatches = 0;
	int        seen_kinds [16];
	bit        stim_done = 1'b0;
	bit        long_hold_done = 1'b0;

	// ------------------------------------------------------------------------
	// Parser state mirror
	// ------------------------------------------------------------------------
	phase_t             ps_phase;
	logic [31:0]        ps_window;
	logic [2:0]         ps_fill;
	logic [9:0]         ps_accum;
	logic [1:0]         ps_digits;
	logic [6:0]         ps_songs;
	logic [6:0]         ps_word_idx;
	logic [7:0]         ps_word_hi;
	logic [15:0]        ps_offset;
	logic [15:0]        ps_tag_start;
	bit                 ps_done;
	result_t            step_res [2];
	int                 step_n;

	function automatic void clear_parser();
		ps_phase     = PH_TAG;
		ps_window    = '0;
		ps_fill      = '0;
		ps_accum     = '0;
		ps_digits    = '0;
		ps_songs     = 7'd1;
		ps_word_idx  = '0;
		ps_word_hi   = '0;
		ps_offset    = '0;
		ps_tag_start = '0;
		ps_done      = 1'b0;
	endfunction

	// at most two events per byte; the rest are dropped
	function automatic void post_event(event_t ev, logic [6:0] idx, logic [15:0] val);
		if (step_n < 2) begin
			step_res[step_n] = '{ev: ev, index: idx, value: val, final_res: 1'b0};
			step_n++;
		end
	endfunction

	function automatic void close_tag(phase_t nxt);
		ps_window = '0;
		ps_fill   = '0;
		ps_phase  = nxt;
	endfunction

	function automatic void start_number(phase_t kind);
		close_tag(kind);
		ps_accum  = '0;
		ps_digits = '0;
	endfunction

	function automatic void start_words(phase_t kind);
		close_tag(ps_songs == 0 ? PH_TAG : kind);
		ps_word_idx = '0;
		ps_word_hi  = '0;
	endfunction

	// number chars: digits only count, zero ends the field
	function automatic void number_char(logic [7:0] b);
		int lim;
		int cap;
		int v;
		lim = (ps_phase >= PH_TA) ? 3 : 2;
		if (b == 8'h00) begin
			cap = (lim == 3) ? int'(NUM_MAX3) : int'(NUM_MAX2);
			v = (int'(ps_accum) > cap) ? cap : int'(ps_accum);
			case (ps_phase)
				PH_SONGS: begin
					ps_songs = 7'(v);
					post_event(EV_SONGS, 7'd0, 16'(v));
				end
				PH_DEFAULT: post_event(EV_DEFAULT, 7'd0, 16'(v));
				PH_VBL:     post_event(EV_VBL, 7'd0, 16'(v));
				default:    post_event(EV_TIMER, 7'((int'(ps_phase) - int'(PH_TA)) & 3), 16'(v));
			endcase
			ps_phase = PH_PAD;
		end else if (ps_digits < lim) begin
			ps_digits++;
			if (b >= CH_0 && b <= CH_9)
				ps_accum = 10'(int'(ps_accum) * 10 + int'(b - CH_0));
		end
	endfunction

	// big-endian words, one per song
	function automatic void word_char(logic [7:0] b);
		logic [15:0] w;
		if (ps_fill == 0) begin
			ps_word_hi = b;
			ps_fill = 3'd1;
			return;
		end
		ps_fill = '0;
		w = {ps_word_hi, b};
		if (ps_phase == PH_SN)
			post_event(EV_NAMEOFS, ps_word_idx, w + ps_tag_start);
		else
			post_event(EV_LENGTH, ps_word_idx, w);
		ps_word_idx++;
		if (ps_word_idx >= ps_songs)
			ps_phase = PH_TAG;
	endfunction

	function automatic void reject_tag();
		post_event(EV_BADTAG, 7'd0, ps_tag_start);
		close_tag(PH_TAG);
		ps_done = 1'b1;
	endfunction

	// tag window: decide as soon as the bytes seen allow
	function automatic void tag_char(logic [7:0] b);
		logic [15:0] pair;
		int hit;
		int sh;
		int i;
		if (ps_fill == 0)
			ps_tag_start = ps_offset;
		ps_window = {ps_window[23:0], b};
		ps_fill++;
		pair = ps_window[15:0];

		if (ps_fill == 2) begin
			if (pair == {CH_HASH, CH_HASH}) begin
				start_number(PH_SONGS);
				return;
			end
			if (pair == {CH_BANG, CH_V}) begin
				start_number(PH_VBL);
				return;
			end
			if (pair[15:8] == CH_T && pair[7:0] >= CH_A && pair[7:0] <= CH_D) begin
				start_number(phase_t'(int'(PH_TA) + int'(pair[7:0] - CH_A)));
				return;
			end
		end
		// "!#" that cannot become "!#SN" is the default-song tag
		if (ps_fill == 3 && ps_window[23:8] == {CH_BANG, CH_HASH} && b != CH_S) begin
			start_number(PH_DEFAULT);
			number_char(b);
			return;
		end
		if (ps_fill == 4 && ps_window[31:8] == {CH_BANG, CH_HASH, CH_S} && b != CH_N) begin
			start_number(PH_DEFAULT);
			number_char(CH_S);
			number_char(b);
			return;
		end
		if (ps_fill >= 4) begin
			hit = NUM_LONG_TAGS;
			for (i = NUM_LONG_TAGS - 1; i >= 0; i--)
				if (LONG_TAGS[i] == ps_window)
					hit = i;
			case (hit)
				LT_HDNS: begin
					post_event(EV_END, 7'd0, 16'(ps_offset + 2));
					close_tag(PH_TAG);
					ps_done = 1'b1;
				end
				LT_TITL: begin
					post_event(EV_TITLE, 7'd0, 16'(ps_offset + 1));
					close_tag(PH_SKIP);
				end
				LT_COMM: begin
					post_event(EV_AUTHOR, 7'd0, 16'(ps_offset + 1));
					close_tag(PH_SKIP);
				end
				LT_RIPP: begin
					post_event(EV_COMMENT, 7'd0, 16'(ps_offset + 1));
					close_tag(PH_SKIP);
				end
				LT_CONV, LT_YEAR: close_tag(PH_SKIP);
				LT_TIME: start_words(PH_TIME);
				LT_SN:   start_words(PH_SN);
				default: reject_tag();
			endcase
			return;
		end
		// still a prefix of some tag?
		sh = 8 * (4 - int'(ps_fill));
		for (i = 0; i < NUM_LONG_TAGS; i++)
			if ((LONG_TAGS[i] >> sh) == ps_window)
				return;
		if (ps_fill == 1 && b == CH_HASH)
			return;
		reject_tag();
	endfunction

	// one accepted byte; events land in step_res[0 .. step_n-1]
	function automatic void parse_byte(logic [7:0] b, logic last);
		step_n = 0;
		if (ps_done)
			return;
		case (ps_phase)
			PH_TAG:  tag_char(b);
			PH_SKIP: if (b == 8'h00) ps_phase = PH_TAG;
			PH_PAD:  if (b != 8'h00) begin
				ps_phase = PH_TAG;
				tag_char(b);
			end
			PH_TIME, PH_SN: word_char(b);
			default: number_char(b);
		endcase
		ps_offset++;
		if (!ps_done && last) begin
			post_event(EV_NOEND, 7'd0, ps_offset);
			ps_done = 1'b1;
		end
		if (step_n > 0)
			step_res[step_n - 1].final_res = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------------
	function automatic void add_byte(logic [7:0] b, logic last = 1'b0);
		byte_req_t r;
		r.data  = b;
		r.last  = last;
		r.typed = 1'b0;
		r.want  = '0;
		byte_plan.insert(byte_plan.size(), r);
	endfunction

	function automatic void add_tag32(logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			add_byte(t[8*i +: 8]);
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c >= CH_0 && c <= CH_9);
		return c;
	endfunction

	function automatic void add_text_body();
		repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(1, 255)));
		add_byte(8'h00);
	endfunction

	// number chars, mostly digits, then terminator and zero padding
	function automatic void add_number_body(logic [7:0] avoid_first);
		int n;
		logic [7:0] c;
		n = $urandom_range(0, 5);
		for (int i = 0; i < n; i++) begin
			c = ($urandom_range(0, 4) < 3) ? 8'(CH_0 + $urandom_range(0, 9))
			                                : 8'($urandom_range(1, 255));
			if (i == 0 && c == avoid_first)
				c = CH_0;
			add_byte(c);
		end
		add_byte(8'h00);
		repeat ($urandom_range(0, 3)) add_byte(8'h00);
	endfunction

	// "##" with a count the generator knows, so word tags stay in step
	function automatic void add_song_count();
		int form;
		int n;
		form = $urandom_range(0, 4);
		n = (form == 4) ? 0 :
		    ($urandom_range(0, 9) == 0) ? $urandom_range(10, 99) : $urandom_range(0, 6);
		if (n >= 10 && (form == 0 || form == 3))
			form = 1;
		add_byte(CH_HASH);
		add_byte(CH_HASH);
		case (form)
			0: add_byte(8'(CH_0 + n));
			1, 2: begin
				add_byte(8'(CH_0 + n / 10));
				add_byte(8'(CH_0 + n % 10));
				if (form == 2)
					repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(1, 255)));
			end
			3: begin
				add_byte(non_digit());
				add_byte(8'(CH_0 + n));
			end
			default: ;
		endcase
		add_byte(8'h00);
		repeat ($urandom_range(0, 3)) add_byte(8'h00);
		gen_songs = n;
	endfunction

	function automatic void add_random_tag();
		int kind;
		kind = $urandom_range(0, 11);
		case (kind)
			0, 1, 2: begin
				add_tag32(LONG_TAGS[int'(LT_TITL) + kind]);
				add_text_body();
			end
			3: begin
				add_tag32(LONG_TAGS[$urandom_range(LT_CONV, LT_YEAR)]);
				add_text_body();
			end
			4, 5: add_song_count();
			6: begin
				add_byte(CH_BANG);
				add_byte(CH_V);
				add_number_body(8'h00);
			end
			7: begin
				add_byte(CH_T);
				add_byte(8'(CH_A + $urandom_range(0, 3)));
				add_number_body(8'h00);
			end
			8: begin
				add_byte(CH_BANG);
				add_byte(CH_HASH);
				// sometimes a broken "!#S" that falls back to the default tag
				if ($urandom_range(0, 2) == 0) begin
					add_byte(CH_S);
					add_number_body(CH_N);
				end else begin
					add_number_body(CH_S);
				end
			end
			default: begin
				add_tag32(LONG_TAGS[$urandom_range(0, 1) ? LT_TIME : LT_SN]);
				repeat (2 * gen_songs) add_byte(8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	// the parse ends once: end tag, bad tag or input running out
	function automatic void add_closing();
		string bad_tags [5] = '{"TE", "#A", "COMX", "HDNX", "Z"};
		int kind;
		int first;
		kind = $urandom_range(0, 2);
		case (kind)
			0: begin
				add_tag32(LONG_TAGS[LT_HDNS]);
				byte_plan[byte_plan.size() - 1].last = 1'($urandom_range(0, 1));
			end
			1: begin
				first = $urandom_range(0, 5);
				if (first == 5)
					add_byte(8'h00);
				else
					for (int i = 0; i < bad_tags[first].len(); i++)
						add_byte(bad_tags[first][i]);
			end
			default: begin
				first = byte_plan.size();
				add_random_tag();
				byte_plan[$urandom_range(first, byte_plan.size() - 1)].last = 1'b1;
			end
		endcase
		// bytes after the finish must give nothing
		repeat (5) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		add_byte(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			mismatches++;
			$error("%s mismatch: expected %0d, got %0d", name, want, seen);
		end
	endfunction

	// events first, then the byte of this edge; its events are checked as they leave the queue
	always @(posedge clk) begin
		result_t oldest;
		if (arst_n) begin
			if (event_ch.valid && event_ch.ready) begin
				events_checked++;
				seen_kinds[event_ch.event_res]++;
				if (pending_events.size() == 0) begin
					mismatches++;
					$error("unexpected event %0d (index %0d, value %0d) with none pending",
					       event_ch.event_res, event_ch.index, event_ch.value);
				end else begin
					oldest = pending_events.pop_front();
					check_field("event_res", oldest.ev, event_ch.event_res);
					check_field("index", oldest.index, event_ch.index);
					check_field("value", oldest.value, event_ch.value);
					check_field("final_res", oldest.final_res, event_ch.final_res);
				end
			end
			if (byte_ch.valid && byte_ch.ready) begin
				if (ps_done)
					bytes_ignored++;
				parse_byte(byte_ch.data_byte, byte_ch.last_byte);
				if (byte_plan[bytes_taken].typed) begin
					pending_events.insert(pending_events.size(),
					                      byte_plan[bytes_taken].want);
				end else begin
					for (int k = 0; k < step_n; k++)
						pending_events.insert(pending_events.size(), step_res[k]);
				end
				bytes_taken++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Byte sender: bursts with random gaps
	// ------------------------------------------------------------------------
	initial begin
		int burst_left;
		int gap;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		burst_left = 0;
		wait (arst_n);
		@(negedge clk);
		foreach (byte_plan[k]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					byte_ch.valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			byte_ch.valid     = 1'b1;
			byte_ch.data_byte = byte_plan[k].data;
			byte_ch.last_byte = byte_plan[k].last;
			do @(posedge clk); while (!byte_ch.ready);
			@(negedge clk);
		end
		byte_ch.valid = 1'b0;
		stim_done = 1'b1;
	end

	// ------------------------------------------------------------------------
	// Event receiver: stall modes of random length, one long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int mode;
		int mode_left;
		event_ch.ready = 1'b0;
		mode_left = 0;
		mode = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && bytes_taken >= 600) begin
				// sender keeps going, so the result queue fills and input stalls
				event_ch.ready = 1'b0;
				repeat (300) @(negedge clk);
				long_hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			case (mode)
				0:       event_ch.ready = 1'b1;
				1:       event_ch.ready = 1'($urandom_range(0, 1));
				default: event_ch.ready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Run control
	// ------------------------------------------------------------------------
	initial begin
		int kinds;
		clear_parser();
		foreach (opening[r]) begin
			add_byte(opening[r].data);
			byte_plan[r].typed = opening[r].typed;
			byte_plan[r].want  = '{ev: opening[r].ev, index: opening[r].idx,
			                       value: opening[r].val, final_res: 1'b1};
		end
		gen_songs = 2;  // the opening sets two songs
		while (byte_plan.size() < 1650)
			add_random_tag();
		add_closing();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (stim_done);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		kinds = 0;
		for (int e = 0; e <= EV_NOEND; e++)
			if (seen_kinds[e] > 0)
				kinds++;
		$display("Fed %0d tag area bytes (%0d after the parse finished), %0d events compared.",
		         bytes_taken, bytes_ignored, events_checked);
		$display("Event kinds seen: %0d of 12; mismatches: %0d.", kinds, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
